FILE: hw/rtl/segment_crossing_point_unit_macros.svh
// assertion macros shared by the crossing point unit
`ifndef SEGMENT_CROSSING_POINT_UNIT_MACROS_SVH
`define SEGMENT_CROSSING_POINT_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define SCP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("scp assertion failed");
`define SCP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scp assertion failed");
`else
`define SCP_ASSERT(label, clk, rst, prop)
`define SCP_ASSERT_IMPL(label, clk, rst, ante, cons)
`endif
`endif

FILE: hw/rtl/scp_pkg.sv
package scp_pkg;

   localparam int CW = 16;
   localparam int FB = 8;
   localparam int OW = 24;
   localparam int DW = CW + 1;
   localparam int PRW = 2 * DW;
   localparam int XW = PRW + 1;
   localparam int NW = XW + DW + 1;
   localparam int MW = NW + FB;
   localparam int QW = CW + FB;

   localparam int MID_DEPTH = 8;
   localparam int MID_AW = $clog2(MID_DEPTH);
   localparam int BACK_LAT = QW + 3;
   localparam int OUT_DEPTH = 1 << $clog2(BACK_LAT + 2);
   localparam int OUT_AW = $clog2(OUT_DEPTH);

   typedef struct packed {
      logic hit;
      logic signed [XW-1:0] den;
      logic signed [XW-1:0] tn;
      logic signed [DW-1:0] dax;
      logic signed [DW-1:0] day;
      logic signed [CW-1:0] a1x;
      logic signed [CW-1:0] a1y;
   } scp_mid_type;

   typedef struct packed {
      logic valid;
      scp_mid_type data;
   } scp_mid_link_type;

   typedef struct packed {
      logic crosses;
      logic signed [OW-1:0] x;
      logic signed [OW-1:0] y;
   } scp_rsp_type;

endpackage

FILE: hw/rtl/scp_divider.sv
module scp_divider
   import scp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [MW-1:0] in_rem,
   input  logic [XW-1:0] in_div,
   output logic          out_valid,
   output logic [QW-1:0] out_quot
);

   logic          v_ff    [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [MW-1:0] rem_ff  [QW-1];
   logic [XW-1:0] div_ff  [QW-1];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      localparam int B = QW - 1 - s;
      logic          v_src;
      logic [MW-1:0] rem_src;
      logic [XW-1:0] div_src;
      logic [QW-1:0] q_src;
      logic [QW-1:0] q_next;
      logic [MW-1:0] trial;
      logic          ge;

      if (s == 0) begin : g_first
         assign v_src   = in_valid;
         assign rem_src = in_rem;
         assign div_src = in_div;
         assign q_src   = '0;
      end else begin : g_next
         assign v_src   = v_ff[s-1];
         assign rem_src = rem_ff[s-1];
         assign div_src = div_ff[s-1];
         assign q_src   = quot_ff[s-1];
      end

      assign trial = MW'(div_src) << B;
      assign ge    = rem_src >= trial;

      always_comb begin
         q_next    = q_src;
         q_next[B] = ge;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else begin
            v_ff[s] <= v_src;
         end
         quot_ff[s] <= q_next;
      end

      if (s < QW - 1) begin : g_keep
         always_ff @(posedge clock) begin
            rem_ff[s] <= ge ? rem_src - trial : rem_src;
            div_ff[s] <= div_src;
         end
      end
   end

   assign out_valid = v_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];

endmodule

FILE: hw/rtl/scp_front.sv
`include "segment_crossing_point_unit_macros.svh"
module scp_front
   import scp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic signed [CW-1:0] a_start_x,
   input  logic signed [CW-1:0] a_start_y,
   input  logic signed [CW-1:0] a_end_x,
   input  logic signed [CW-1:0] a_end_y,
   input  logic signed [CW-1:0] b_start_x,
   input  logic signed [CW-1:0] b_start_y,
   input  logic signed [CW-1:0] b_end_x,
   input  logic signed [CW-1:0] b_end_y,
   output scp_mid_link_type     mid,
   input  logic                 mid_take
);

   logic accept;

   // difference stage
   logic                 v0_ff;
   logic signed [DW-1:0] dax0_ff, day0_ff, dbx0_ff, dby0_ff, rx0_ff, ry0_ff;
   logic signed [CW-1:0] a1x0_ff, a1y0_ff;

   // product stage
   logic                  v1_ff;
   logic signed [PRW-1:0] pd1_ff, pd2_ff, pt1_ff, pt2_ff, pu1_ff, pu2_ff;
   logic signed [DW-1:0]  dax1_ff, day1_ff;
   logic signed [CW-1:0]  a1x1_ff, a1y1_ff;

   // cross product and classify
   logic signed [XW-1:0] den, tn, un, den_n, tn_n, un_n;
   logic                 flip;
   logic                 v2_ff;
   scp_mid_type          e2_ff;

   // queue toward the back end
   scp_mid_type       mid_mem [MID_DEPTH];
   logic [MID_AW-1:0] mid_wr_ff, mid_rd_ff;
   logic [MID_AW:0]   mid_cnt_ff, mid_cnt_in;
   logic [MID_AW:0]   front_used_ff, front_used_in;

   assign full   = front_used_ff == (MID_AW+1)'(MID_DEPTH);
   assign accept = push && !full;

   always_ff @(posedge clock) begin
      dax0_ff <= DW'(a_end_x) - DW'(a_start_x);
      day0_ff <= DW'(a_end_y) - DW'(a_start_y);
      dbx0_ff <= DW'(b_end_x) - DW'(b_start_x);
      dby0_ff <= DW'(b_end_y) - DW'(b_start_y);
      rx0_ff  <= DW'(b_start_x) - DW'(a_start_x);
      ry0_ff  <= DW'(b_start_y) - DW'(a_start_y);
      a1x0_ff <= a_start_x;
      a1y0_ff <= a_start_y;

      pd1_ff  <= PRW'(dax0_ff) * PRW'(dby0_ff);
      pd2_ff  <= PRW'(day0_ff) * PRW'(dbx0_ff);
      pt1_ff  <= PRW'(rx0_ff) * PRW'(dby0_ff);
      pt2_ff  <= PRW'(ry0_ff) * PRW'(dbx0_ff);
      pu1_ff  <= PRW'(rx0_ff) * PRW'(day0_ff);
      pu2_ff  <= PRW'(ry0_ff) * PRW'(dax0_ff);
      dax1_ff <= dax0_ff;
      day1_ff <= day0_ff;
      a1x1_ff <= a1x0_ff;
      a1y1_ff <= a1y0_ff;
   end

   always_comb begin
      den   = XW'(pd1_ff) - XW'(pd2_ff);
      tn    = XW'(pt1_ff) - XW'(pt2_ff);
      un    = XW'(pu1_ff) - XW'(pu2_ff);
      flip  = den < 0;
      den_n = flip ? -den : den;
      tn_n  = flip ? -tn : tn;
      un_n  = flip ? -un : un;
   end

   always_ff @(posedge clock) begin
      e2_ff.hit <= (tn_n > 0) && (tn_n < den_n) && (un_n > 0) && (un_n < den_n);
      e2_ff.den <= den_n;
      e2_ff.tn  <= tn_n;
      e2_ff.dax <= dax1_ff;
      e2_ff.day <= day1_ff;
      e2_ff.a1x <= a1x1_ff;
      e2_ff.a1y <= a1y1_ff;
      if (v2_ff) begin
         mid_mem[mid_wr_ff] <= e2_ff;
      end
   end

   assign mid_cnt_in    = mid_cnt_ff + (MID_AW+1)'(v2_ff) - (MID_AW+1)'(mid_take);
   assign front_used_in = front_used_ff + (MID_AW+1)'(accept) - (MID_AW+1)'(mid_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff         <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         mid_wr_ff     <= '0;
         mid_rd_ff     <= '0;
         mid_cnt_ff    <= '0;
         front_used_ff <= '0;
      end else begin
         v0_ff         <= accept;
         v1_ff         <= v0_ff;
         v2_ff         <= v1_ff;
         mid_wr_ff     <= mid_wr_ff + MID_AW'(v2_ff);
         mid_rd_ff     <= mid_rd_ff + MID_AW'(mid_take);
         mid_cnt_ff    <= mid_cnt_in;
         front_used_ff <= front_used_in;
      end
   end

   assign mid.valid = mid_cnt_ff != '0;
   assign mid.data  = mid_mem[mid_rd_ff];

   `SCP_ASSERT(a_mid_within_used, clock, reset, mid_cnt_ff <= front_used_ff)
   `SCP_ASSERT_IMPL(a_take_needs_entry, clock, reset, mid_take, mid_cnt_ff != '0)

endmodule

FILE: hw/rtl/scp_back.sv
`include "segment_crossing_point_unit_macros.svh"
module scp_back
   import scp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  scp_mid_link_type mid,
   output logic             mid_take,
   output logic             empty,
   input  logic             pop,
   output scp_rsp_type      rsp
);

   typedef struct packed {
      logic hit;
      logic negx;
      logic negy;
   } scp_side_type;

   // entry stage
   logic        v0_ff;
   scp_mid_type e0_ff;

   // numerator products
   logic                 v1_ff, hit1_ff;
   logic signed [NW-1:0] px1_ff, px2_ff, py1_ff, py2_ff;
   logic [XW-1:0]        den1_ff;

   // magnitude and scale
   logic signed [NW-1:0] numx, numy;
   logic [NW-1:0]        magx, magy;
   logic                 v2_ff;
   logic [MW-1:0]        remx_ff, remy_ff;
   logic [XW-1:0]        div2_ff;
   scp_side_type         side2_ff;
   scp_side_type         side_ff [QW];

   // quotient lanes
   logic                 div_x_valid, div_y_valid;
   logic [QW-1:0]        quot_x, quot_y;
   logic signed [QW:0]   qx, qy, sx, sy;
   scp_rsp_type          res;

   // result queue
   scp_rsp_type       out_mem [OUT_DEPTH];
   logic [OUT_AW-1:0] out_wr_ff, out_rd_ff;
   logic [OUT_AW:0]   out_cnt_ff, out_cnt_in;
   logic [OUT_AW:0]   back_used_ff, back_used_in;
   logic              pop_acc;

   assign mid_take = mid.valid && (back_used_ff < (OUT_AW+1)'(OUT_DEPTH));
   assign pop_acc  = pop && !empty;

   always_ff @(posedge clock) begin
      e0_ff   <= mid.data;

      px1_ff  <= NW'(e0_ff.a1x) * NW'(e0_ff.den);
      px2_ff  <= NW'(e0_ff.tn) * NW'(e0_ff.dax);
      py1_ff  <= NW'(e0_ff.a1y) * NW'(e0_ff.den);
      py2_ff  <= NW'(e0_ff.tn) * NW'(e0_ff.day);
      den1_ff <= e0_ff.den;
      hit1_ff <= e0_ff.hit;
   end

   always_comb begin
      numx = px1_ff + px2_ff;
      numy = py1_ff + py2_ff;
      magx = numx < 0 ? -numx : numx;
      magy = numy < 0 ? -numy : numy;
   end

   always_ff @(posedge clock) begin
      remx_ff       <= MW'(magx) << FB;
      remy_ff       <= MW'(magy) << FB;
      div2_ff       <= den1_ff;
      side2_ff.hit  <= hit1_ff;
      side2_ff.negx <= numx < 0;
      side2_ff.negy <= numy < 0;
      side_ff[0]    <= side2_ff;
      for (int i = 1; i < QW; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   scp_divider u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rem    (remx_ff),
      .in_div    (div2_ff),
      .out_valid (div_x_valid),
      .out_quot  (quot_x)
   );

   scp_divider u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_rem    (remy_ff),
      .in_div    (div2_ff),
      .out_valid (div_y_valid),
      .out_quot  (quot_y)
   );

   always_comb begin
      qx          = $signed({1'b0, quot_x});
      qy          = $signed({1'b0, quot_y});
      sx          = side_ff[QW-1].negx ? -qx : qx;
      sy          = side_ff[QW-1].negy ? -qy : qy;
      res.crosses = side_ff[QW-1].hit;
      res.x       = side_ff[QW-1].hit ? OW'(sx) : '0;
      res.y       = side_ff[QW-1].hit ? OW'(sy) : '0;
   end

   always_ff @(posedge clock) begin
      if (div_x_valid) begin
         out_mem[out_wr_ff] <= res;
      end
   end

   assign out_cnt_in   = out_cnt_ff + (OUT_AW+1)'(div_x_valid) - (OUT_AW+1)'(pop_acc);
   assign back_used_in = back_used_ff + (OUT_AW+1)'(mid_take) - (OUT_AW+1)'(pop_acc);

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_cnt_ff   <= '0;
         back_used_ff <= '0;
      end else begin
         v0_ff        <= mid_take;
         v1_ff        <= v0_ff;
         v2_ff        <= v1_ff;
         out_wr_ff    <= out_wr_ff + OUT_AW'(div_x_valid);
         out_rd_ff    <= out_rd_ff + OUT_AW'(pop_acc);
         out_cnt_ff   <= out_cnt_in;
         back_used_ff <= back_used_in;
      end
   end

   assign empty = out_cnt_ff == '0;
   assign rsp   = out_mem[out_rd_ff];

   `SCP_ASSERT(a_out_within_used, clock, reset, out_cnt_ff <= back_used_ff)
   `SCP_ASSERT(a_lanes_aligned, clock, reset, div_x_valid == div_y_valid)
   `SCP_ASSERT_IMPL(a_no_out_overflow, clock, reset, div_x_valid, out_cnt_ff < (OUT_AW+1)'(OUT_DEPTH))

endmodule

FILE: hw/rtl/segment_crossing_point_unit.sv
// Proper crossing test of two signed 16-bit line segments with the crossing point
// in signed 24-bit fixed point (8 fraction bits, truncated toward zero); both
// coordinates read 0 when there is no crossing, and touching, parallel or
// collinear segments never cross. One transaction is accepted per clock while
// full is low, and one result comes out per clock while pop is high and empty
// is low; most of a transaction's path to the result ports lies in the 24-step
// restoring quotient pipeline of the back end. The front end (cross products,
// classification) and the back end (numerators, quotients) are joined by an
// 8-entry queue, and a 32-entry result queue lets pop stall without stopping
// push until both queues fill.
module segment_crossing_point_unit
   import scp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  logic signed [CW-1:0] req_a_start_x,
   input  logic signed [CW-1:0] req_a_start_y,
   input  logic signed [CW-1:0] req_a_end_x,
   input  logic signed [CW-1:0] req_a_end_y,
   input  logic signed [CW-1:0] req_b_start_x,
   input  logic signed [CW-1:0] req_b_start_y,
   input  logic signed [CW-1:0] req_b_end_x,
   input  logic signed [CW-1:0] req_b_end_y,
   output logic                 empty,
   input  logic                 pop,
   output logic                 rsp_crosses,
   output logic signed [OW-1:0] rsp_cross_x,
   output logic signed [OW-1:0] rsp_cross_y
);

   scp_mid_link_type mid;
   logic             mid_take;
   scp_rsp_type      rsp;

   scp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .a_start_x (req_a_start_x),
      .a_start_y (req_a_start_y),
      .a_end_x   (req_a_end_x),
      .a_end_y   (req_a_end_y),
      .b_start_x (req_b_start_x),
      .b_start_y (req_b_start_y),
      .b_end_x   (req_b_end_x),
      .b_end_y   (req_b_end_y),
      .mid       (mid),
      .mid_take  (mid_take)
   );

   scp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .mid      (mid),
      .mid_take (mid_take),
      .empty    (empty),
      .pop      (pop),
      .rsp      (rsp)
   );

   assign rsp_crosses = rsp.crosses;
   assign rsp_cross_x = rsp.x;
   assign rsp_cross_y = rsp.y;

endmodule
